// File: design/assert_macros.svh
// Assertion macros used by the guidance FSM
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Implication property, disabled while reset is asserted
`define OAG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset
`define OAG_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`else

`define OAG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define OAG_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: design/oag_pkg.sv
// Types, codes and reset values for the obstacle avoidance guidance block
`timescale 1ns / 1ps

package oag_pkg;

  // Field widths
  localparam int BLOB_W = 20;
  localparam int POS_W  = 12;
  localparam int SAFE_W = 8;
  localparam int FWD_W  = 8;
  localparam int TURN_W = 12;
  localparam int MODE_W = 3;
  localparam int VEL_W  = 2;
  localparam int RATE_W = 2;

  // Configuration port geometry
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_FORWARD  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_AVOID_R  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AVOID_L  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STOPTURN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FORCED   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SEARCH   = 3'd5;

  // Velocity codes
  localparam logic [VEL_W-1:0] VEL_NONE = 2'd0;
  localparam logic [VEL_W-1:0] VEL_FWD  = 2'd1;
  localparam logic [VEL_W-1:0] VEL_HOLD = 2'd2;
  localparam logic [VEL_W-1:0] VEL_REV  = 2'd3;

  // Heading rate codes
  localparam logic [RATE_W-1:0] RATE_NONE = 2'd0;
  localparam logic [RATE_W-1:0] RATE_POS  = 2'd1;
  localparam logic [RATE_W-1:0] RATE_NEG  = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_DANGER_THR = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_EDGE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_EDGE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SAFE_CONF  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FWD_LIMIT  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TURN_LIMIT = 3'd5;

  // Register reset values
  localparam logic [BLOB_W-1:0] RST_DANGER_THR = 20'd12000;
  localparam logic [POS_W-1:0]  RST_LEFT_EDGE  = 12'd72;
  localparam logic [POS_W-1:0]  RST_RIGHT_EDGE = 12'd168;
  localparam logic [SAFE_W-1:0] RST_SAFE_CONF  = 8'd5;
  localparam logic [FWD_W-1:0]  RST_FWD_LIMIT  = 8'd40;
  localparam logic [TURN_W-1:0] RST_TURN_LIMIT = 12'd69;

  typedef struct packed {
    logic              req_type;
    logic              guided;
    logic              found;
    logic [BLOB_W-1:0] blob_count;
    logic [POS_W-1:0]  centroid_x;
    logic              coin;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode_now;
    logic [VEL_W-1:0]  vel_cmd;
    logic [RATE_W-1:0] rate_cmd;
    logic              lock_heading;
    logic              danger_seen;
  } result_t;

  typedef struct packed {
    logic [BLOB_W-1:0] hazard_thr;
    logic [POS_W-1:0]  left_edge;
    logic [POS_W-1:0]  right_edge;
    logic [SAFE_W-1:0] safe_confirm;
    logic [FWD_W-1:0]  forward_limit;
    logic [TURN_W-1:0] turn_limit;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SAFE_W-1:0] safe_count;
    logic [FWD_W-1:0]  forward_count;
    logic [TURN_W-1:0] turn_count;
    logic              turn_left;
  } state_t;

endpackage

// File: design/oag_chan_if.sv
// Valid/ready channel interfaces for detection items and guidance results
`timescale 1ns / 1ps

interface oag_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic                       guided;
  logic                       found;
  logic [oag_pkg::BLOB_W-1:0] blob_count;
  logic [oag_pkg::POS_W-1:0]  centroid_x;
  logic                       coin;

  modport source (
    output valid, req_type, guided, found, blob_count, centroid_x, coin,
    input  ready
  );
  modport sink (
    input  valid, req_type, guided, found, blob_count, centroid_x, coin,
    output ready
  );
endinterface

interface oag_out_if;
  logic                       valid;
  logic                       ready;
  logic [oag_pkg::MODE_W-1:0] mode_now;
  logic [oag_pkg::VEL_W-1:0]  vel_cmd;
  logic [oag_pkg::RATE_W-1:0] rate_cmd;
  logic                       lock_heading;
  logic                       danger_seen;

  modport source (
    output valid, mode_now, vel_cmd, rate_cmd, lock_heading, danger_seen,
    input  ready
  );
  modport sink (
    input  valid, mode_now, vel_cmd, rate_cmd, lock_heading, danger_seen,
    output ready
  );
endinterface

// File: design/obstacle_avoid_guidance_fsm.sv
// An accepted item is held in the input register; its result is then loaded into the result register.
// Throughput: one item per cycle, set by the combinational tick logic between
// the input register and the result register; stalls only on output back-pressure.
// Reset (rst_n low, synchronous) clears the mode to search, all counters, the
// turn direction, both valid flags, and returns the registers to their defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module obstacle_avoid_guidance_fsm (
  input  logic                       clk,
  input  logic                       rst_n,
  oag_in_if.sink                     in_chan,
  oag_out_if.source                  out_chan,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [oag_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [oag_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [oag_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  oag_pkg::cfg_t    cfg;
  oag_pkg::item_t   item_r;
  logic             in_valid_r;
  oag_pkg::state_t  st_r;
  oag_pkg::state_t  st_nxt;
  oag_pkg::result_t res_nxt;
  oag_pkg::result_t res_r;
  logic             out_valid_r;
  logic             advance;
  logic             in_ready;

  oag_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  oag_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Flow control: the held item moves on when the result slot is free
  assign advance        = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready       = !in_valid_r || advance;
  assign in_chan.ready  = in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      item_r.req_type   <= in_chan.req_type;
      item_r.guided     <= in_chan.guided;
      item_r.found      <= in_chan.found;
      item_r.blob_count <= in_chan.blob_count;
      item_r.centroid_x <= in_chan.centroid_x;
      item_r.coin       <= in_chan.coin;
    end
  end

  // Guidance state, updated once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode          <= oag_pkg::MODE_SEARCH;
      st_r.safe_count    <= '0;
      st_r.forward_count <= '0;
      st_r.turn_count    <= '0;
      st_r.turn_left     <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.mode_now     = res_r.mode_now;
  assign out_chan.vel_cmd      = res_r.vel_cmd;
  assign out_chan.rate_cmd     = res_r.rate_cmd;
  assign out_chan.lock_heading = res_r.lock_heading;
  assign out_chan.danger_seen  = res_r.danger_seen;

  // Checks
  `OAG_ASSERT_IMPL(a_stall_only_on_backpressure, clk, rst_n, !in_ready, out_valid_r && in_valid_r && !out_chan.ready, "input stalled without output back-pressure")
  `OAG_ASSERT_IMPL(a_lock_modes, clk, rst_n, out_valid_r && res_r.lock_heading, res_r.mode_now == oag_pkg::MODE_FORWARD || res_r.mode_now == oag_pkg::MODE_SEARCH, "heading lock outside forward or search")
  `OAG_ASSERT_IMPL(a_reverse_to_search, clk, rst_n, out_valid_r && res_r.vel_cmd == oag_pkg::VEL_REV, res_r.mode_now == oag_pkg::MODE_SEARCH && !res_r.danger_seen, "reverse without return to search")
  `OAG_ASSERT_IMPL(a_state_tracks_result, clk, rst_n, advance, ##1 (res_r.mode_now == st_r.mode), "result mode differs from stored mode")

endmodule

// File: design/oag_cfg_regs.sv
// APB-style configuration registers for the guidance block
`timescale 1ns / 1ps

module oag_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [oag_pkg::ADDR_W-1:0] paddr,
  input  logic [oag_pkg::DATA_W-1:0] pwdata,
  output logic [oag_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output oag_pkg::cfg_t              cfg
);

  oag_pkg::cfg_t                 cfg_r;
  logic [oag_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[oag_pkg::REG_IDX_W+1:2];
  assign wr_en   = psel & penable & pwrite;
  assign cfg     = cfg_r;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hazard_thr    <= oag_pkg::RST_DANGER_THR;
      cfg_r.left_edge     <= oag_pkg::RST_LEFT_EDGE;
      cfg_r.right_edge    <= oag_pkg::RST_RIGHT_EDGE;
      cfg_r.safe_confirm  <= oag_pkg::RST_SAFE_CONF;
      cfg_r.forward_limit <= oag_pkg::RST_FWD_LIMIT;
      cfg_r.turn_limit    <= oag_pkg::RST_TURN_LIMIT;
    end else if (wr_en) begin
      unique case (reg_idx)
        oag_pkg::REG_DANGER_THR: cfg_r.hazard_thr    <= pwdata[oag_pkg::BLOB_W-1:0];
        oag_pkg::REG_LEFT_EDGE:  cfg_r.left_edge     <= pwdata[oag_pkg::POS_W-1:0];
        oag_pkg::REG_RIGHT_EDGE: cfg_r.right_edge    <= pwdata[oag_pkg::POS_W-1:0];
        oag_pkg::REG_SAFE_CONF:  cfg_r.safe_confirm  <= pwdata[oag_pkg::SAFE_W-1:0];
        oag_pkg::REG_FWD_LIMIT:  cfg_r.forward_limit <= pwdata[oag_pkg::FWD_W-1:0];
        oag_pkg::REG_TURN_LIMIT: cfg_r.turn_limit    <= pwdata[oag_pkg::TURN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux, zero-extended
  always_comb begin
    unique case (reg_idx)
      oag_pkg::REG_DANGER_THR: prdata = oag_pkg::DATA_W'(cfg_r.hazard_thr);
      oag_pkg::REG_LEFT_EDGE:  prdata = oag_pkg::DATA_W'(cfg_r.left_edge);
      oag_pkg::REG_RIGHT_EDGE: prdata = oag_pkg::DATA_W'(cfg_r.right_edge);
      oag_pkg::REG_SAFE_CONF:  prdata = oag_pkg::DATA_W'(cfg_r.safe_confirm);
      oag_pkg::REG_FWD_LIMIT:  prdata = oag_pkg::DATA_W'(cfg_r.forward_limit);
      oag_pkg::REG_TURN_LIMIT: prdata = oag_pkg::DATA_W'(cfg_r.turn_limit);
      default:                 prdata = '0;
    endcase
  end

endmodule

// File: design/oag_step.sv
// Next-state and command logic for one guidance tick
`timescale 1ns / 1ps

module oag_step (
  input  oag_pkg::cfg_t    cfg,
  input  oag_pkg::state_t  st,
  input  oag_pkg::item_t   item,
  output oag_pkg::state_t  st_nxt,
  output oag_pkg::result_t res
);

  logic                        danger;
  logic [oag_pkg::SAFE_W-1:0]  safe_inc;
  logic [oag_pkg::FWD_W-1:0]   fwd_inc;
  logic [oag_pkg::TURN_W-1:0]  turn_inc;
  logic [oag_pkg::RATE_W-1:0]  turn_rate;

  // Saturating increments and shared terms
  assign danger    = item.found && (item.blob_count > cfg.hazard_thr);
  assign safe_inc  = (&st.safe_count) ? st.safe_count : st.safe_count + 8'd1;
  assign fwd_inc   = (&st.forward_count) ? st.forward_count : st.forward_count + 8'd1;
  assign turn_inc  = (&st.turn_count) ? st.turn_count : st.turn_count + 12'd1;
  assign turn_rate = st.turn_left ? oag_pkg::RATE_NEG : oag_pkg::RATE_POS;

  always_comb begin
    st_nxt           = st;
    res.mode_now     = st.mode;
    res.vel_cmd      = oag_pkg::VEL_NONE;
    res.rate_cmd     = oag_pkg::RATE_NONE;
    res.lock_heading = 1'b0;
    res.danger_seen  = 1'b0;

    priority if (item.req_type) begin
      // Retreat: back off and restart the search
      res.vel_cmd          = oag_pkg::VEL_REV;
      st_nxt.mode          = oag_pkg::MODE_SEARCH;
      st_nxt.safe_count    = '0;
      st_nxt.forward_count = '0;
      st_nxt.turn_count    = '0;
    end else if (!item.guided) begin
      st_nxt.mode          = oag_pkg::MODE_SEARCH;
      st_nxt.safe_count    = '0;
      st_nxt.forward_count = '0;
      st_nxt.turn_count    = '0;
    end else begin
      res.danger_seen   = danger;
      st_nxt.safe_count = danger ? '0 : safe_inc;

      unique case (st.mode)
        oag_pkg::MODE_SEARCH: begin
          st_nxt.forward_count = '0;
          st_nxt.turn_count    = '0;
          res.rate_cmd         = oag_pkg::RATE_POS;
          if (st_nxt.safe_count >= cfg.safe_confirm) begin
            res.lock_heading  = 1'b1;
            st_nxt.mode       = oag_pkg::MODE_FORWARD;
            st_nxt.safe_count = '0;
          end
        end
        oag_pkg::MODE_FORWARD: begin
          if (danger) begin
            st_nxt.forward_count = '0;
            // Pick the avoidance side from the centroid column
            priority if (item.centroid_x < cfg.left_edge) begin
              st_nxt.turn_left = 1'b0;
              st_nxt.mode      = oag_pkg::MODE_AVOID_R;
            end else if (item.centroid_x > cfg.right_edge) begin
              st_nxt.turn_left = 1'b1;
              st_nxt.mode      = oag_pkg::MODE_AVOID_L;
            end else begin
              st_nxt.turn_left = item.coin;
              st_nxt.mode      = oag_pkg::MODE_STOPTURN;
            end
          end else begin
            res.vel_cmd = oag_pkg::VEL_FWD;
            if (fwd_inc >= cfg.forward_limit) begin
              st_nxt.forward_count = '0;
              st_nxt.turn_count    = '0;
              st_nxt.turn_left     = 1'b0;
              st_nxt.mode          = oag_pkg::MODE_FORCED;
            end else begin
              st_nxt.forward_count = fwd_inc;
            end
          end
        end
        oag_pkg::MODE_AVOID_R, oag_pkg::MODE_AVOID_L, oag_pkg::MODE_STOPTURN: begin
          st_nxt.forward_count = '0;
          res.vel_cmd          = oag_pkg::VEL_HOLD;
          res.rate_cmd         = turn_rate;
          if (st_nxt.safe_count >= cfg.safe_confirm) begin
            res.lock_heading  = 1'b1;
            st_nxt.mode       = oag_pkg::MODE_FORWARD;
            st_nxt.safe_count = '0;
          end
        end
        oag_pkg::MODE_FORCED: begin
          res.vel_cmd  = oag_pkg::VEL_HOLD;
          res.rate_cmd = turn_rate;
          if (turn_inc >= cfg.turn_limit) begin
            res.lock_heading  = 1'b1;
            st_nxt.turn_count = '0;
            st_nxt.safe_count = '0;
            st_nxt.mode       = oag_pkg::MODE_SEARCH;
          end else begin
            st_nxt.turn_count = turn_inc;
          end
        end
        default: begin
          // Unused mode codes fall back to search
          st_nxt.mode = oag_pkg::MODE_SEARCH;
        end
      endcase
    end

    res.mode_now = st_nxt.mode;
  end

endmodule
